FILE: design/pts_pkg.sv
package pts_pkg;

   // Field widths fixed by the interface
   localparam int TICK_W = 16;
   localparam int CNT_W  = 3;

   typedef logic [TICK_W-1:0] tick_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   // A task counts as due while it is late by less than this
   localparam tick_type OVERRUN_LIMIT = 16'd32767;

   // Register file layout
   localparam cnt_type REG_TASK_COUNT = 3'd0;
   localparam cnt_type REG_PERIOD_0   = 3'd1;

   // Reset values
   localparam tick_type PERIOD_RESET = 16'd1;
   localparam cnt_type  COUNT_RESET  = 3'd6;

endpackage

FILE: design/periodic_task_scheduler.sv
// Channel   Ports                                         Direction  Handshake
// request   start, busy, req_now_ticks                    in         start & !busy
// response  rsp_valid, rsp_chosen_task, rsp_wake_time,   out        rsp_valid, one cycle
//           rsp_run_now
// config    csr_we, csr_index, csr_wdata                  in         csr_we, no wait
//
// Each word takes an add step, which adds the period of the task that just ran,
// then a scan in which one shared subtract/compare unit visits the tasks one a
// cycle, from task 0 up to the task count, stopping early at the first due task.
// The response strobe comes in the cycle busy falls; a new start is taken then.
// Reset clears all due times, sets task 0 current, task count 6 and periods 1.
// The receiver cannot stall: each response shows for exactly one cycle.
module periodic_task_scheduler #(
   parameter int MAX_TASKS = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   // request
   input  logic                     start,
   output logic                     busy,
   input  logic [pts_pkg::TICK_W-1:0] req_now_ticks,
   // response
   output logic                     rsp_valid,
   output logic [pts_pkg::CNT_W-1:0]  rsp_chosen_task,
   output logic [pts_pkg::TICK_W-1:0] rsp_wake_time,
   output logic                     rsp_run_now,
   // configuration
   input  logic                     csr_we,
   input  logic [pts_pkg::CNT_W-1:0]  csr_index,
   input  logic [pts_pkg::TICK_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam pts_pkg::cnt_type MAX_CNT = pts_pkg::CNT_W'(MAX_TASKS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ADD  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       cur_ff, cur_in;
   pts_pkg::tick_type      now_ff, now_in;
   pts_pkg::tick_type      best_sleep_ff, best_sleep_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   pts_pkg::tick_type      best_due_ff, best_due_in;
   pts_pkg::cnt_type       task_count_ff;
   pts_pkg::tick_type      period_ff [MAX_TASKS];
   pts_pkg::tick_type      due_ff [MAX_TASKS];

   logic                   rsp_valid_ff, rsp_valid_in;
   pts_pkg::cnt_type       rsp_task_ff, rsp_task_in;
   pts_pkg::tick_type      rsp_wake_ff, rsp_wake_in;
   logic                   rsp_run_ff, rsp_run_in;

   logic                   due_we;
   pts_pkg::tick_type      due_sum;
   pts_pkg::tick_type      due_rd;
   pts_pkg::tick_type      overrun;
   pts_pkg::tick_type      sleep;
   logic                   is_due;
   logic                   is_better;
   logic [IDX_W-1:0]       last_idx;
   pts_pkg::cnt_type       csr_slot;

   // Clamp the task count to 1 .. MAX_TASKS
   always_comb begin
      if (task_count_ff == '0) begin
         last_idx = '0;
      end else if (task_count_ff > MAX_CNT) begin
         last_idx = IDX_W'(MAX_TASKS - 1);
      end else begin
         last_idx = IDX_W'(task_count_ff - 3'd1);
      end
   end

   // Shared unit: one entry read, one add or subtract/compare per cycle
   assign due_rd    = due_ff[idx_ff];
   assign due_sum   = due_rd + period_ff[idx_ff];
   assign overrun   = now_ff - due_rd;
   assign sleep     = due_rd - now_ff;
   assign is_due    = overrun < pts_pkg::OVERRUN_LIMIT;
   assign is_better = sleep < best_sleep_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      now_in        = now_ff;
      best_sleep_in = best_sleep_ff;
      best_idx_in   = best_idx_ff;
      best_due_in   = best_due_ff;
      rsp_valid_in  = 1'b0;
      rsp_task_in   = rsp_task_ff;
      rsp_wake_in   = rsp_wake_ff;
      rsp_run_in    = rsp_run_ff;
      due_we        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in   = cur_ff;
               now_in   = req_now_ticks;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            // advance the task that just ran, seed the fallback choice
            due_we        = 1'b1;
            best_sleep_in = '1;
            best_idx_in   = idx_ff;
            best_due_in   = due_sum;
            idx_in        = '0;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            if (is_due) begin
               rsp_valid_in = 1'b1;
               rsp_task_in  = pts_pkg::CNT_W'(idx_ff);
               rsp_wake_in  = due_rd;
               rsp_run_in   = 1'b1;
               cur_in       = idx_ff;
               state_in     = ST_IDLE;
            end else begin
               if (is_better) begin
                  best_sleep_in = sleep;
                  best_idx_in   = idx_ff;
                  best_due_in   = due_rd;
               end
               if (idx_ff == last_idx) begin
                  rsp_valid_in = 1'b1;
                  rsp_task_in  = pts_pkg::CNT_W'(best_idx_in);
                  rsp_wake_in  = best_due_in;
                  rsp_run_in   = 1'b0;
                  cur_in       = best_idx_in;
                  state_in     = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      now_ff        <= now_in;
      best_sleep_ff <= best_sleep_in;
      best_idx_ff   <= best_idx_in;
      best_due_ff   <= best_due_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_wake_ff   <= rsp_wake_in;
      rsp_run_ff    <= rsp_run_in;
   end

   // Due times: cleared by reset, written back by the add step
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            due_ff[i] <= '0;
         end
      end else if (due_we) begin
         due_ff[idx_ff] <= due_sum;
      end
   end

   // Configuration writes; slots at or beyond MAX_TASKS are dropped
   assign csr_slot = csr_index - pts_pkg::REG_PERIOD_0;

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= pts_pkg::COUNT_RESET;
         for (int i = 0; i < MAX_TASKS; i++) begin
            period_ff[i] <= pts_pkg::PERIOD_RESET;
         end
      end else if (csr_we) begin
         if (csr_index == pts_pkg::REG_TASK_COUNT) begin
            task_count_ff <= csr_wdata[pts_pkg::CNT_W-1:0];
         end else if (csr_slot < MAX_CNT) begin
            period_ff[csr_slot[IDX_W-1:0]] <= csr_wdata;
         end
      end
   end

   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_task = rsp_task_ff;
   assign rsp_wake_time   = rsp_wake_ff;
   assign rsp_run_now     = rsp_run_ff;

endmodule
